// ===== design/json_string_escaper_utf8_check_unit_macros.svh =====
// assertion macros used by the unit's datapath
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_MACROS_SVH

// same cycle implication
`define JSEU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jseu assertion failed");

// next cycle implication
`define JSEU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jseu assertion failed");

`endif

// ===== design/jseu_pkg.sv =====
package jseu_pkg;

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_UESC  = 2'd2
   } kind_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic hold;
      logic emit_last;
      logic out_free;
   } status_type;

   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_UESC  = 3'd6;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [15:0] CP_REPLACE = 16'hFFFD;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) begin
         return 8'h30 + {4'h0, d};
      end
      return 8'h37 + {4'h0, d};
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      if (b >= 8'hC2 && b <= 8'hDF) begin
         return 3'd2;
      end
      if (b >= 8'hE0 && b <= 8'hEF) begin
         return 3'd3;
      end
      if (b >= 8'hF0 && b <= 8'hF4) begin
         return 3'd4;
      end
      return 3'd0;
   endfunction

   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
      case (lead)
         8'hE0: return b >= 8'hA0 && b <= 8'hBF;
         8'hED: return b >= 8'h80 && b <= 8'h9F;
         8'hF0: return b >= 8'h90 && b <= 8'hBF;
         8'hF4: return b >= 8'h80 && b <= 8'h8F;
         default: return is_cont(b);
      endcase
   endfunction

endpackage

// ===== design/json_string_escaper_utf8_check_unit.sv =====
// an input word passes the load, decide and emit states; each byte leaves through the output register
// each input word yields zero or more escaped sequences, emission waiting while rsp_stall holds
//   the output register: 1 byte for plain ascii, 2 for short escapes, 6 for \uXXXX, 2..4 for raw utf-8
// one input word in work at a time, set by the decide/emit sequencer and its output register
// reset: synchronous active high, clears the pending count, the output valid and the controller state
module json_string_escaper_utf8_check_unit
   import jseu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   cmd_type    cmd;
   status_type status;

   jseu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jseu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

// ===== design/jseu_ctrl.sv =====
module jseu_ctrl
   import jseu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.empty || status.hold) begin
               state_in = ST_IDLE;
            end else begin
               cmd.decide = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/jseu_datapath.sv =====
`include "json_string_escaper_utf8_check_unit_macros.svh"

module jseu_datapath
   import jseu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic [7:0]  buf_ff [4];
   logic [7:0]  buf_in [4];
   logic [2:0]  cnt_ff, cnt_in;
   logic        end_ff, end_in;
   kind_type    kind_ff, kind_in;
   logic [2:0]  len_ff, len_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  use_ff, use_in;
   logic [15:0] cp_ff, cp_in;
   logic [7:0]  esc_ff, esc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   kind_type    kind_d;
   logic [2:0]  len_d, use_d, need;
   logic [15:0] cp_d;
   logic [7:0]  esc_d, b0, b1, b2, b3, emit_byte;
   logic        bad, wait_d, emit_last, out_free;
   logic [2:0]  remain;

   assign b0 = buf_ff[0];
   assign b1 = buf_ff[1];
   assign b2 = buf_ff[2];
   assign b3 = buf_ff[3];

   // decision for the sequence at the head of the buffer
   always_comb begin
      kind_d = KIND_RAW;
      len_d  = 3'd1;
      use_d  = 3'd1;
      cp_d   = {8'h00, b0};
      esc_d  = b0;
      bad    = 1'b0;
      wait_d = 1'b0;
      need   = lead_length(b0);
      if (!b0[7]) begin
         case (b0)
            CH_QUOTE:  begin kind_d = KIND_SHORT; esc_d = CH_QUOTE;  end
            CH_BSLASH: begin kind_d = KIND_SHORT; esc_d = CH_BSLASH; end
            8'h08:     begin kind_d = KIND_SHORT; esc_d = 8'h62;     end
            8'h0C:     begin kind_d = KIND_SHORT; esc_d = 8'h66;     end
            8'h0A:     begin kind_d = KIND_SHORT; esc_d = 8'h6E;     end
            8'h0D:     begin kind_d = KIND_SHORT; esc_d = 8'h72;     end
            8'h09:     begin kind_d = KIND_SHORT; esc_d = 8'h74;     end
            default: begin
               if (b0 < CH_SPACE || b0 == CH_DEL) begin
                  kind_d = KIND_UESC;
               end
            end
         endcase
         if (kind_d == KIND_SHORT) begin
            len_d = LEN_SHORT;
         end else if (kind_d == KIND_UESC) begin
            len_d = LEN_UESC;
         end
      end else begin
         if (need == 3'd0) begin
            bad = 1'b1;
         end else begin
            if (cnt_ff >= 3'd2 && !second_ok(b0, b1)) begin
               bad = 1'b1;
            end
            if (need >= 3'd3 && cnt_ff >= 3'd3 && !is_cont(b2)) begin
               bad = 1'b1;
            end
            if (need == 3'd4 && cnt_ff >= 3'd4 && !is_cont(b3)) begin
               bad = 1'b1;
            end
            if (!bad && cnt_ff < need) begin
               if (end_ff) begin
                  bad = 1'b1;
               end else begin
                  wait_d = 1'b1;
               end
            end
         end
         if (bad) begin
            kind_d = KIND_UESC;
            len_d  = LEN_UESC;
            cp_d   = CP_REPLACE;
         end else if (need == 3'd2 && b0 == 8'hC2 && b1 <= 8'h9F) begin
            kind_d = KIND_UESC;
            len_d  = LEN_UESC;
            use_d  = need;
            cp_d   = {8'h00, b1};
         end else if (need == 3'd3 && b0 == 8'hE2 && b1 == 8'h80 &&
                      (b2 == 8'hA8 || b2 == 8'hA9)) begin
            kind_d = KIND_UESC;
            len_d  = LEN_UESC;
            use_d  = need;
            cp_d   = {8'h20, 2'b00, b2[5:0]};
         end else begin
            len_d = need;
            use_d = need;
         end
      end
   end

   always_comb begin
      emit_byte = buf_ff[idx_ff[1:0]];
      case (kind_ff)
         KIND_SHORT: emit_byte = (idx_ff == 3'd0) ? CH_BSLASH : esc_ff;
         KIND_UESC: begin
            case (idx_ff)
               3'd0:    emit_byte = CH_BSLASH;
               3'd1:    emit_byte = CH_U;
               3'd2:    emit_byte = hex_char(cp_ff[15:12]);
               3'd3:    emit_byte = hex_char(cp_ff[11:8]);
               3'd4:    emit_byte = hex_char(cp_ff[7:4]);
               default: emit_byte = hex_char(cp_ff[3:0]);
            endcase
         end
         default: emit_byte = buf_ff[idx_ff[1:0]];
      endcase
   end

   assign emit_last = idx_ff == (len_ff - 3'd1);
   assign remain    = cnt_ff - use_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign status.empty     = cnt_ff == 3'd0;
   assign status.hold      = wait_d;
   assign status.emit_last = emit_last;
   assign status.out_free  = out_free;

   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      use_in       = use_ff;
      cp_in        = cp_ff;
      esc_in       = esc_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         buf_in[cnt_ff[1:0]] = req_in_byte;
         cnt_in              = cnt_ff + 3'd1;
         end_in              = req_string_end;
      end
      if (cmd.decide) begin
         kind_in = kind_d;
         len_in  = len_d;
         use_in  = use_d;
         cp_in   = cp_d;
         esc_in  = esc_d;
         idx_in  = 3'd0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last && end_ff && (remain == 3'd0);
         idx_in       = idx_ff + 3'd1;
         if (emit_last) begin
            cnt_in = remain;
            case (use_ff)
               3'd1: begin
                  buf_in[0] = buf_ff[1];
                  buf_in[1] = buf_ff[2];
                  buf_in[2] = buf_ff[3];
               end
               3'd2: begin
                  buf_in[0] = buf_ff[2];
                  buf_in[1] = buf_ff[3];
               end
               3'd3: begin
                  buf_in[0] = buf_ff[3];
               end
               default: begin
                  buf_in = buf_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      end_ff      <= end_in;
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      use_ff      <= use_in;
      cp_ff       <= cp_in;
      esc_ff      <= esc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   `JSEU_ASSERT_IMP(a_load_room, clock, reset, cmd.load, cnt_ff <= 3'd3)
   `JSEU_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, out_free)
   `JSEU_ASSERT_IMP(a_decide_nonempty, clock, reset, cmd.decide, cnt_ff != 3'd0)
   `JSEU_ASSERT_NXT(a_load_count, clock, reset, cmd.load, cnt_ff != 3'd0)

endmodule

// ===== tb/sv/tb_json_string_escaper_utf8_check_unit.sv =====
module tb_json_string_escaper_utf8_check_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import jseu_pkg::*;

   localparam int RESET_CYCLES = 6;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [20:0] CP_LS  = 21'h2028;
   localparam logic [20:0] CP_PS  = 21'h2029;
   localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } raw_word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } esc_word_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   raw_word_type src_bytes_q[$];
   esc_word_type esc_text_q[$];
   logic [7:0]   step_bytes[$];
   logic [7:0]   str_buf[$];
   logic [7:0]   seq_buf[4];
   int           seq_n;

   // predictor state
   logic [7:0] pend_bytes[3];
   logic [1:0] pend_cnt = 2'd0;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int err_count   = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   logic hold_go   = 1'b0;
   logic hold_used = 1'b0;

   json_string_escaper_utf8_check_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int seq_len_of(input logic [7:0] b);
      if (b < 8'hC2) begin
         return 0;
      end else if (b < 8'hE0) begin
         return 2;
      end else if (b < 8'hF0) begin
         return 3;
      end else if (b < 8'hF5) begin
         return 4;
      end
      return 0;
   endfunction

   function automatic void second_bounds(input logic [7:0] lead, output logic [7:0] lo,
                                         output logic [7:0] hi);
      lo = 8'h80;
      hi = 8'hBF;
      case (lead)
         8'hE0: lo = 8'hA0;
         8'hED: hi = 8'h9F;
         8'hF0: lo = 8'h90;
         8'hF4: hi = 8'h8F;
         default: ;
      endcase
   endfunction

   function automatic void add_exp(input logic [7:0] b);
      step_bytes = {step_bytes, b};
   endfunction

   function automatic void push_uhex(input logic [15:0] cp);
      int k;
      add_exp(CH_BSLASH);
      add_exp(CH_U);
      for (k = 3; k >= 0; k--) begin
         add_exp(HEX_DIGITS[8 * (15 - int'(cp[4 * k +: 4])) +: 8]);
      end
   endfunction

   function automatic void push_plain(input logic [7:0] b);
      case (b)
         CH_QUOTE: begin
            add_exp(CH_BSLASH);
            add_exp(CH_QUOTE);
         end
         CH_BSLASH: begin
            add_exp(CH_BSLASH);
            add_exp(CH_BSLASH);
         end
         CTL_BS: begin
            add_exp(CH_BSLASH);
            add_exp("b");
         end
         CTL_FF: begin
            add_exp(CH_BSLASH);
            add_exp("f");
         end
         CTL_LF: begin
            add_exp(CH_BSLASH);
            add_exp("n");
         end
         CTL_CR: begin
            add_exp(CH_BSLASH);
            add_exp("r");
         end
         CTL_TAB: begin
            add_exp(CH_BSLASH);
            add_exp("t");
         end
         default: begin
            if (b < CH_SPACE || b == CH_DEL) begin
               push_uhex({8'h00, b});
            end else begin
               add_exp(b);
            end
         end
      endcase
   endfunction

   // expected escaped text for one accepted word
   task automatic escape_word(input logic [7:0] in_b, input logic str_end);
      logic [7:0] win[4];
      logic [7:0] lo, hi;
      logic [20:0] cp;
      logic bad, stop;
      int n, need, have, consume, i;
      esc_word_type w;
      step_bytes.delete();
      n = int'(pend_cnt);
      for (i = 0; i < n; i++) begin
         win[i] = pend_bytes[i];
      end
      win[n] = in_b;
      n++;
      stop = 1'b0;
      while (n > 0 && !stop) begin
         consume = 1;
         bad = 1'b0;
         need = 1;
         if (win[0] < 8'h80) begin
            push_plain(win[0]);
         end else begin
            need = seq_len_of(win[0]);
            if (need == 0) begin
               bad = 1'b1;
            end else begin
               have = (n < need) ? n : need;
               second_bounds(win[0], lo, hi);
               for (i = 1; i < have; i++) begin
                  if (!bad) begin
                     if (i == 1) begin
                        bad = win[i] < lo || win[i] > hi;
                     end else begin
                        bad = win[i][7:6] != 2'b10;
                     end
                  end
               end
               if (!bad && n < need) begin
                  if (str_end) begin
                     bad = 1'b1;
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            if (!stop) begin
               if (bad) begin
                  push_uhex(CP_REPLACE);
               end else begin
                  if (need == 2) begin
                     cp = {10'd0, win[0][4:0], win[1][5:0]};
                  end else if (need == 3) begin
                     cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
                  end else begin
                     cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
                  end
                  if ((cp >= 21'h80 && cp <= 21'h9F) || cp == CP_LS || cp == CP_PS) begin
                     push_uhex(cp[15:0]);
                  end else begin
                     for (i = 0; i < need; i++) begin
                        add_exp(win[i]);
                     end
                  end
                  consume = need;
               end
            end
         end
         if (!stop) begin
            for (i = 0; i < n - consume; i++) begin
               win[i] = win[i + consume];
            end
            n -= consume;
         end
      end
      pend_cnt = 2'(n);
      for (i = 0; i < n; i++) begin
         pend_bytes[i] = win[i];
      end
      for (i = 0; i < step_bytes.size(); i++) begin
         w.ch = step_bytes[i];
         w.last = str_end && (i == step_bytes.size() - 1);
         esc_text_q = {esc_text_q, w};
      end
   endtask

   // driver
   always @(posedge clock) begin : req_drive
      raw_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            escape_word(req_in_byte, req_string_end);
         end
         if (!req_valid || !req_stall) begin
            if (src_bytes_q.size() != 0 && int'($urandom_range(0, 99)) >= idle_pct) begin
               nxt = src_bytes_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= nxt.data;
               req_string_end <= nxt.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_check
      esc_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (esc_text_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected word: expected none, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_out_last);
            end else begin
               want = esc_text_q.pop_front();
               if (rsp_out_byte !== want.ch) begin
                  err_count++;
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, want.ch, rsp_out_byte);
               end
               if (rsp_out_last !== want.last) begin
                  err_count++;
                  $display("%0t: out_last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_out_last);
               end
            end
         end
         rsp_stall <= (hold_left != 0) || (int'($urandom_range(0, 99)) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_word(input logic [7:0] b, input logic fin);
      raw_word_type w;
      w.data = b;
      w.fin = fin;
      src_bytes_q = {src_bytes_q, w};
   endtask

   task automatic make_seq(input int len);
      logic [7:0] lo, hi;
      int i;
      seq_n = len;
      if (len == 2) begin
         seq_buf[0] = ($urandom_range(0, 3) == 0) ? 8'hC2 : 8'($urandom_range(8'hC2, 8'hDF));
      end else if (len == 3) begin
         seq_buf[0] = ($urandom_range(0, 4) == 0) ? 8'hE2 : 8'($urandom_range(8'hE0, 8'hEF));
      end else begin
         seq_buf[0] = 8'($urandom_range(8'hF0, 8'hF4));
      end
      second_bounds(seq_buf[0], lo, hi);
      seq_buf[1] = 8'($urandom_range(hi, lo));
      for (i = 2; i < len; i++) begin
         seq_buf[i] = 8'($urandom_range(8'h80, 8'hBF));
      end
      // line and paragraph separators and their neighbouring code points
      if (len == 3 && seq_buf[0] == 8'hE2 && $urandom_range(0, 1) == 0) begin
         seq_buf[1] = 8'h80;
         seq_buf[2] = 8'($urandom_range(8'hA7, 8'hAA));
      end
   endtask

   task automatic add_char();
      int pick, k, i;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         str_buf = {str_buf, 8'($urandom_range(8'h20, 8'h7E))};
      end else if (pick < 31) begin
         str_buf = {str_buf, (($urandom_range(0, 1) == 0) ? CH_QUOTE : CH_BSLASH)};
      end else if (pick < 40) begin
         str_buf = {str_buf,
                    (($urandom_range(0, 7) == 0) ? CH_DEL : 8'($urandom_range(0, 31)))};
      end else if (pick < 80) begin
         make_seq($urandom_range(2, 4));
         for (i = 0; i < seq_n; i++) begin
            str_buf = {str_buf, seq_buf[i]};
         end
      end else if (pick < 88) begin
         str_buf = {str_buf, 8'($urandom_range(0, 255))};
      end else if (pick < 94) begin
         // truncated sequence
         make_seq($urandom_range(2, 4));
         k = $urandom_range(1, seq_n - 1);
         for (i = 0; i < k; i++) begin
            str_buf = {str_buf, seq_buf[i]};
         end
      end else begin
         // corrupted continuation
         make_seq($urandom_range(2, 4));
         seq_buf[$urandom_range(1, seq_n - 1)] = 8'($urandom_range(0, 255));
         for (i = 0; i < seq_n; i++) begin
            str_buf = {str_buf, seq_buf[i]};
         end
      end
   endtask

   task automatic gen_string();
      int chars, i;
      str_buf.delete();
      chars = $urandom_range(1, 10);
      for (i = 0; i < chars; i++) begin
         add_char();
      end
      for (i = 0; i < str_buf.size(); i++) begin
         queue_word(str_buf[i], i == str_buf.size() - 1);
      end
   endtask

   task automatic wait_accepted();
      while (src_bytes_q.size() != 0 || req_valid) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int words);
      int queued;
      @(negedge clock);
      idle_pct = idle;
      stall_pct = stall;
      queued = 0;
      while (queued < words) begin
         gen_string();
         queued += str_buf.size();
      end
      wait_accepted();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every escape, then the utf-8 corner cases
      queue_word(8'h00, 1'b0);
      queue_word(CH_QUOTE, 1'b0);
      queue_word(CH_BSLASH, 1'b0);
      queue_word(CTL_BS, 1'b0);
      queue_word(CTL_FF, 1'b0);
      queue_word(CTL_LF, 1'b0);
      queue_word(CTL_CR, 1'b0);
      queue_word(CTL_TAB, 1'b0);
      queue_word(CH_DEL, 1'b0);
      queue_word(8'h7E, 1'b1);
      // c1 control
      queue_word(8'hC2, 1'b0);
      queue_word(8'h80, 1'b0);
      // paragraph separator
      queue_word(8'hE2, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'hA9, 1'b0);
      // overlong, surrogate, bad lead
      queue_word(8'hE0, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'hED, 1'b0);
      queue_word(8'hA0, 1'b0);
      queue_word(8'hFF, 1'b0);
      // three pending bytes broken by a control at string end
      queue_word(8'hF0, 1'b0);
      queue_word(8'h90, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'h00, 1'b1);
      // truncated at string end
      queue_word(8'hE2, 1'b0);
      queue_word(8'h82, 1'b1);
      wait_accepted();

      run_phase(0, 0, 80);
      run_phase(71, 0, 75);
      run_phase(0, 71, 75);
      run_phase(24, 24, 80);
      @(negedge clock);
      hold_go = 1'b1;
      run_phase(0, 0, 70);

      while (esc_text_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/jseu_pkg.sv
design/jseu_ctrl.sv
design/jseu_datapath.sv
design/json_string_escaper_utf8_check_unit.sv
tb/sv/tb_json_string_escaper_utf8_check_unit.sv
